### rtl/dstq_pkg.sv
// shared types and codes for the deadline sorted task queue
package dstq_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned DL_W     = 32;
  localparam int unsigned CT_W     = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // operation carried by an input transaction
  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_DELETE = 1'b1
  } mode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

  // one stored queue entry
  typedef struct packed {
    logic [ID_W-1:0] task_id;
    logic [DL_W-1:0] deadline;
    logic [CT_W-1:0] created_at;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage : dstq_pkg

### rtl/dstq_if.sv
// valid/ready channel interfaces for task requests and queue results
interface dstq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [dstq_pkg::ID_W-1:0]   task_id;
  logic [dstq_pkg::DL_W-1:0]   deadline;
  logic [dstq_pkg::CT_W-1:0]   created_at;

  modport source (output valid, mode, task_id, deadline, created_at, input ready);
  modport sink   (input valid, mode, task_id, deadline, created_at, output ready);
endinterface : dstq_in_if

interface dstq_out_if;
  logic                          valid;
  logic                          ready;
  logic [dstq_pkg::STATUS_W-1:0] status;
  logic                          head_valid;
  logic [dstq_pkg::ID_W-1:0]     head_task_id;
  logic [dstq_pkg::DL_W-1:0]     head_deadline;
  logic [dstq_pkg::CT_W-1:0]     head_created_at;
  logic [dstq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, head_valid, head_task_id, head_deadline,
                  head_created_at, occupancy, input ready);
  modport sink   (input valid, status, head_valid, head_task_id, head_deadline,
                  head_created_at, occupancy, output ready);
endinterface : dstq_out_if

### rtl/dstq_ram.sv
// generic single write port, single read port ram with registered read
module dstq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : dstq_ram

### rtl/deadline_sorted_task_queue.sv
// top level of the deadline sorted task queue
// Keeps up to QUEUE_DEPTH tasks in one entry RAM, sorted by ascending deadline; an insert
// goes ahead of entries with an equal or later deadline, a delete removes the first entry
// with the given task id, and every transaction returns one result with the status, the
// head entry and the occupancy. One request is worked at a time: an insert walks from the
// tail toward its place, moving each later entry up one place, and writes the new entry
// there; a delete walks the whole queue from the first entry; a full insert or a delete
// on an empty queue finishes with no walk. The walk reads one entry per read state and
// compare state through the single registered read port of the entry RAM and the one
// shared comparator. The input is not ready during a walk; a finished result waits in the
// output register while the next request is taken.
module deadline_sorted_task_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  dstq_in_if.sink   in_chan,
  dstq_out_if.source out_chan
);
  import dstq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_INS_RD  = 6'b000010,
    ST_INS_CMP = 6'b000100,
    ST_INS_WR  = 6'b001000,
    ST_DEL_RD  = 6'b010000,
    ST_DEL_CMP = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic          finish_r, finish_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  status_t       status_r, status_nxt;
  entry_t        req_r, req_nxt;
  entry_t        head_r;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r;
  logic [CW-1:0] out_count_r;
  entry_t        out_head_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] idx_inc;
  logic          cmp_hit;
  logic          in_fire;
  logic          out_fire;
  logic          out_load;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_valid_r && out_chan.ready;
  assign out_load = finish_r && (!out_valid_r || out_chan.ready);
  assign idx_dec  = idx_r - 1'b1;
  assign idx_inc  = idx_r + 1'b1;

  // entry storage
  dstq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared comparator: deadline order on insert, id match on delete
  always_comb begin
    if (state_r == ST_DEL_CMP) begin
      cmp_hit = (rd_data.task_id == req_r.task_id);
    end else begin
      cmp_hit = (rd_data.deadline >= req_r.deadline);
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    finish_nxt = finish_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    req_nxt    = req_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r[AW-1:0];
    wr_data    = req_r;
    rd_addr    = idx_r[AW-1:0];

    if (out_load) begin
      finish_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt.task_id    = in_chan.task_id;
          req_nxt.deadline   = in_chan.deadline;
          req_nxt.created_at = in_chan.created_at;
          found_nxt          = 1'b0;
          status_nxt         = STATUS_DONE;
          if (mode_t'(in_chan.mode) == MODE_INSERT) begin
            if (count_r == DEPTH_C) begin
              status_nxt = STATUS_FULL;
              finish_nxt = 1'b1;
            end else begin
              idx_nxt   = count_r;
              state_nxt = (count_r == '0) ? ST_INS_WR : ST_INS_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STATUS_NOT_FOUND;
              finish_nxt = 1'b1;
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_DEL_RD;
            end
          end
        end
      end
      ST_INS_RD: begin
        rd_addr   = idx_dec[AW-1:0];
        state_nxt = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        wr_en = 1'b1;
        if (cmp_hit) begin
          // entry below moves up one place
          wr_data   = rd_data;
          idx_nxt   = idx_dec;
          state_nxt = (idx_dec == '0) ? ST_INS_WR : ST_INS_RD;
        end else begin
          count_nxt  = count_r + 1'b1;
          finish_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_INS_WR: begin
        wr_en      = 1'b1;
        count_nxt  = count_r + 1'b1;
        finish_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_DEL_RD: begin
        state_nxt = ST_DEL_CMP;
      end
      ST_DEL_CMP: begin
        // after the match every entry moves down one place
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = idx_dec[AW-1:0];
          wr_data = rd_data;
        end else if (cmp_hit) begin
          found_nxt = 1'b1;
        end
        idx_nxt = idx_inc;
        if (idx_inc == count_r) begin
          if (found_r || cmp_hit) begin
            count_nxt = count_r - 1'b1;
          end else begin
            status_nxt = STATUS_NOT_FOUND;
          end
          finish_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_DEL_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_chan.ready = (state_r == ST_IDLE) && !finish_r;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      finish_r    <= 1'b0;
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      finish_r    <= finish_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    req_r    <= req_nxt;
    // head copy follows every write to the first slot
    if (wr_en && (wr_addr == '0)) begin
      head_r <= wr_data;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_count_r  <= count_r;
      out_head_r   <= head_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.head_valid      = (out_count_r != '0);
  assign out_chan.head_task_id    = (out_count_r != '0) ? out_head_r.task_id : '0;
  assign out_chan.head_deadline   = (out_count_r != '0) ? out_head_r.deadline : '0;
  assign out_chan.head_created_at =
    (out_count_r != '0) ? out_head_r.created_at : '0;
  assign out_chan.occupancy       = OCC_W'(out_count_r);

  // occupancy never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above queue depth");

  // occupancy moves by one at most per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=>
      (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
       count_r + 1'b1 == $past(count_r)))
    else $error("entry count jumped");

  // delete walk stays inside the occupied entries
  a_del_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEL_CMP) |-> (idx_r < count_r))
    else $error("delete walk past occupied entries");

  // insert into a full queue is dropped with the full status
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode_t'(in_chan.mode) == MODE_INSERT && count_r == DEPTH_C) |=>
      (finish_r && status_r == STATUS_FULL && count_r == DEPTH_C))
    else $error("full insert not dropped");

endmodule : deadline_sorted_task_queue
